/* design/gprm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gated pulse RPM meter package
// Shared widths, register indexes, reset values and the result word type.
// ----------------------------------------------------------------------------
package gprm_pkg;

   localparam int COUNT_WIDTH_DEF = 24;
   localparam int TOTAL_W = 24;
   localparam int RPM_W = 30;
   localparam int WIN_W = 8;
   localparam int PPR_W = 8;
   localparam int SPS_W = 20;
   localparam int DIV_W = WIN_W + PPR_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 20;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPS = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd1;
   localparam logic [PPR_W-1:0] PPR_RESET = 8'd2;
   localparam logic [SPS_W-1:0] SPS_RESET = 20'd10000;

   typedef struct packed {
      logic [TOTAL_W-1:0] pulse_total;
      logic [RPM_W-1:0] speed_rpm;
      logic count_saturated;
   } result_type;

endpackage
`default_nettype wire

/* design/gprm_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer of a few words held in flip-flops.
// ----------------------------------------------------------------------------
module gprm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire logic [WIDTH-1:0] push_data,
   output logic full,
   input wire logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* design/gprm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gated pulse RPM meter front end
// Holds the configuration, counts rising edges and sample ticks, and issues
// one job word with the count, saturation flag and divisor at each window end.
// ----------------------------------------------------------------------------
module gprm_front #(
   parameter int COUNT_WIDTH = gprm_pkg::COUNT_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [gprm_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [gprm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input wire logic sample_valid,
   input wire logic pin_level,
   output logic job_push,
   output logic [COUNT_WIDTH-1:0] job_count,
   output logic job_saturated,
   output logic [gprm_pkg::DIV_W-1:0] job_divisor
);
   import gprm_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [WIN_W-1:0] window_ff;
   logic [PPR_W-1:0] ppr_ff;
   logic [SPS_W-1:0] sps_ff;

   logic primed_ff, primed_in;
   logic prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic sat_ff, sat_in;
   logic [SPS_W-1:0] tick_ff, tick_in;
   logic [WIN_W-1:0] sec_ff, sec_in;

   logic rise;
   logic [COUNT_WIDTH-1:0] count_next;
   logic sat_next;
   logic [SPS_W-1:0] tick_next, sps_eff;
   logic [WIN_W-1:0] sec_next, window_eff;
   logic [PPR_W-1:0] ppr_eff;
   logic second_done, window_done;

   assign window_eff = (window_ff == '0) ? WIN_W'(1) : window_ff;
   assign ppr_eff = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign sps_eff = (sps_ff == '0) ? SPS_W'(1) : sps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         ppr_ff <= PPR_RESET;
         sps_ff <= SPS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW: window_ff <= csr_wdata[WIN_W-1:0];
            CSR_PPR: ppr_ff <= csr_wdata[PPR_W-1:0];
            CSR_SPS: sps_ff <= csr_wdata[SPS_W-1:0];
            default: ;
         endcase
      end
   end

   assign rise = pin_level && !prev_ff;
   assign count_next = (rise && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign sat_next = sat_ff || (rise && count_next == COUNT_MAX);
   assign tick_next = tick_ff + 1'b1;
   assign second_done = (tick_next >= sps_eff);
   assign sec_next = second_done ? sec_ff + 1'b1 : sec_ff;
   assign window_done = (sec_next >= window_eff);

   always_comb begin
      primed_in = primed_ff;
      prev_in = prev_ff;
      count_in = count_ff;
      sat_in = sat_ff;
      tick_in = tick_ff;
      sec_in = sec_ff;
      job_push = 1'b0;
      if (sample_valid) begin
         prev_in = pin_level;
         if (!primed_ff) begin
            primed_in = 1'b1;
         end else if (window_done) begin
            job_push = 1'b1;
            count_in = '0;
            sat_in = 1'b0;
            tick_in = '0;
            sec_in = '0;
         end else begin
            count_in = count_next;
            sat_in = sat_next;
            tick_in = second_done ? '0 : tick_next;
            sec_in = sec_next;
         end
      end
   end

   assign job_count = count_next;
   assign job_saturated = sat_next;
   assign job_divisor = DIV_W'(window_eff) * DIV_W'(ppr_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         prev_ff <= 1'b0;
         count_ff <= '0;
         sat_ff <= 1'b0;
         tick_ff <= '0;
         sec_ff <= '0;
      end else begin
         primed_ff <= primed_in;
         prev_ff <= prev_in;
         count_ff <= count_in;
         sat_ff <= sat_in;
         tick_ff <= tick_in;
         sec_ff <= sec_in;
      end
   end

endmodule
`default_nettype wire

/* design/gprm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gated pulse RPM meter back end
// Takes one job word, scales the count by sixty, divides it by the divisor
// one quotient bit per cycle and delivers the clamped result word.
// ----------------------------------------------------------------------------
module gprm_back #(
   parameter int COUNT_WIDTH = gprm_pkg::COUNT_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic job_empty,
   input wire logic [COUNT_WIDTH-1:0] job_count,
   input wire logic job_saturated,
   input wire logic [gprm_pkg::DIV_W-1:0] job_divisor,
   output logic job_pop,
   input wire logic res_full,
   output logic res_push,
   output gprm_pkg::result_type res_data
);
   import gprm_pkg::*;

   localparam int DW = COUNT_WIDTH + 6;
   localparam int STEP_W = $clog2(DW + 1);
   localparam int EXT_W = 38;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BUSY = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic sat_ff, sat_in;

   logic [DW-1:0] dividend;
   logic [31:0] count_ext;
   logic [DIV_W:0] trial;
   logic fits;
   logic [EXT_W-1:0] quo_ext;

   assign dividend = (DW'(job_count) << 6) - (DW'(job_count) << 2);
   assign count_ext = 32'(job_count);
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign fits = (trial >= {1'b0, div_ff});
   assign quo_ext = EXT_W'(quo_ff);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      total_in = total_ff;
      sat_in = sat_ff;
      job_pop = 1'b0;
      res_push = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               quo_in = dividend;
               rem_in = '0;
               div_in = job_divisor;
               total_in = (|count_ext[31:TOTAL_W]) ? '1 : count_ext[TOTAL_W-1:0];
               sat_in = job_saturated;
               step_in = STEP_W'(DW);
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            rem_in = fits ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];
            quo_in = {quo_ff[DW-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res_data.pulse_total = total_ff;
   assign res_data.speed_rpm = (|quo_ext[EXT_W-1:RPM_W]) ? '1 : quo_ext[RPM_W-1:0];
   assign res_data.count_saturated = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      total_ff <= total_in;
      sat_ff <= sat_in;
   end

endmodule
`default_nettype wire

/* design/gated_pulse_rpm_meter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gated pulse RPM meter
// Counts rising edges of a sampled pulse input over a window of whole
// seconds and reports the pulse total and the shaft speed in RPM.
//
// Each word pushed on the req_ side is one sample of the pin. The first
// sample after reset only sets the previous level. Later samples count
// edges and time; the sample that completes the window yields one result
// word, read on the rsp_ side with empty and pop. A sample is taken in
// the cycle it is pushed while the job queue has room, so one sample per
// cycle is accepted. At a window end the back end pops the job, runs it
// through its one-bit-per-cycle restoring divider and pushes the result
// word, taking no new job until then; the word waits in a two-entry
// result queue. Two jobs can wait behind the divider, so full rises
// only when windows end faster than the divider or when unread result
// words fill the result queue and the jobs back up behind it.
// Reset clears all counters and queues and loads the register defaults:
// window 1 second, 2 pulses per revolution, 10000 samples per second.
// Registers are written through the csr_ port with no wait.
// ----------------------------------------------------------------------------
module gated_pulse_rpm_meter #(
   parameter int COUNT_WIDTH = gprm_pkg::COUNT_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [gprm_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [gprm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input wire logic push,
   output logic full,
   input wire logic req_pin_level,
   input wire logic pop,
   output logic empty,
   output logic [gprm_pkg::TOTAL_W-1:0] rsp_pulse_total,
   output logic [gprm_pkg::RPM_W-1:0] rsp_speed_rpm,
   output logic rsp_count_saturated
);
   import gprm_pkg::*;

   localparam int JOB_W = COUNT_WIDTH + 1 + DIV_W;
   localparam int RES_W = $bits(result_type);

   logic job_push, job_pop, job_full, job_empty;
   logic [COUNT_WIDTH-1:0] fe_count, be_count;
   logic fe_sat, be_sat;
   logic [DIV_W-1:0] fe_div, be_div;
   logic [JOB_W-1:0] job_wdata, job_rdata;
   logic res_push, res_full;
   result_type res_wdata, res_rdata;
   logic [RES_W-1:0] res_rbits;

   assign full = job_full;

   gprm_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .sample_valid(push && !job_full),
      .pin_level(req_pin_level),
      .job_push(job_push),
      .job_count(fe_count),
      .job_saturated(fe_sat),
      .job_divisor(fe_div)
   );

   assign job_wdata = {fe_count, fe_sat, fe_div};
   assign {be_count, be_sat, be_div} = job_rdata;

   gprm_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_job_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(job_wdata),
      .full(job_full),
      .pop(job_pop),
      .pop_data(job_rdata),
      .empty(job_empty)
   );

   gprm_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(job_empty),
      .job_count(be_count),
      .job_saturated(be_sat),
      .job_divisor(be_div),
      .job_pop(job_pop),
      .res_full(res_full),
      .res_push(res_push),
      .res_data(res_wdata)
   );

   gprm_fifo #(
      .WIDTH(RES_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_res_queue (
      .clock(clock),
      .reset(reset),
      .push(res_push),
      .push_data(res_wdata),
      .full(res_full),
      .pop(pop),
      .pop_data(res_rbits),
      .empty(empty)
   );

   assign res_rdata = res_rbits;
   assign rsp_pulse_total = res_rdata.pulse_total;
   assign rsp_speed_rpm = res_rdata.speed_rpm;
   assign rsp_count_saturated = res_rdata.count_saturated;

endmodule
`default_nettype wire
